// ----- src/lfcu_pkg.sv -----
// Shared constants, types and arithmetic helpers for the fire column update core.
// No dependencies; imported by led_fire_column_update_core.
package lfcu_pkg;

   // Cube geometry and field widths
   localparam int SIDE     = 8;
   localparam int Z_W      = $clog2(SIDE);
   localparam int COORD_W  = 3;
   localparam int ROW_AW   = 2 * COORD_W;
   localparam int ROWS     = 1 << ROW_AW;
   localparam int HEAT_W   = 8;
   localparam int ROW_W    = SIDE * HEAT_W;
   localparam int LEVEL_W  = 8;

   typedef logic [HEAT_W-1:0] heat_type;

   // Random source
   localparam logic [31:0] PRNG_SEED = 32'd2463534242;
   localparam int          DRAW_W    = 15;

   // Shared remainder unit: 16 dividend bits, 4 bits per cycle, divisor up to 256
   localparam int MOD_W     = 9;
   localparam int DVD_W     = 16;
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = DVD_W / MOD_BITS;
   localparam int MOD_CW    = $clog2(MOD_STEPS);

   // Flame constants
   localparam logic [MOD_W-1:0]  COOL_SPAN   = 9'd36;
   localparam logic [HEAT_W-1:0] COOL_BASE   = 8'd80;
   localparam logic [MOD_W-1:0]  SPARK_SPAN  = 9'd106;
   localparam logic [HEAT_W-1:0] SPARK_BASE  = 8'd100;
   localparam logic [HEAT_W-1:0] LOSS_BASE   = 8'd2;
   localparam logic [MOD_W-1:0]  HEAT_RANGE  = 9'd256;
   localparam logic [15:0]       HEAT_SCALE  = 16'd191;
   localparam logic [LEVEL_W-1:0] RED_FULL   = 8'd255;
   localparam logic [LEVEL_W-1:0] RED_RAMP   = 8'd165;
   localparam logic [LEVEL_W-1:0] GREEN_FULL = 8'd200;
   localparam logic [LEVEL_W-1:0] GREEN_RAMP = 8'd210;

   // xorshift32 with shifts 13, 17, 5
   function automatic logic [31:0] xorshift(input logic [31:0] v);
      logic [31:0] a;
      a = v ^ (v << 13);
      a = a ^ (a >> 17);
      a = a ^ (a << 5);
      return a;
   endfunction

   // floor(x / 3) for x below 768, by reciprocal 683 / 2048
   function automatic heat_type div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[18:11];
   endfunction

   // floor(x / 255) for x below 256 * 255, the bound that callers stay below
   function automatic logic [LEVEL_W-1:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   // Height ramp: (coef * z) / SIDE
   function automatic logic [LEVEL_W-1:0] ramp(input logic [LEVEL_W-1:0] coef,
                                               input logic [Z_W-1:0] z);
      logic [15:0] p;
      p = 16'(coef) * 16'(z);
      return LEVEL_W'(p / SIDE);
   endfunction

endpackage

// ----- src/led_fire_column_update_core.sv -----
// Fire column update core: heat row memory, remainder unit, sequencer and color pipe.
// Depends on lfcu_pkg.
//
// Usage: pulse start with req_column_x / req_column_y while busy is low; the
// transfer happens on that edge. The core reads the column's heat row from its
// memory (one row per column, SIDE cells of 8 bits), cools each cell by a
// random loss, lets heat rise, maybe adds a spark near the bottom, writes the
// row back, then emits SIDE pixels, bottom first, one per cycle on rsp_*
// marked by rsp_valid. rsp_last_pixel flags the top pixel.
// Timing: eleven or thirteen draws per column; the ten or eleven remainders
// among them go through one shared restoring remainder unit and set the
// pace. busy stays high from the start transfer and drops while the last
// pixel is on rsp_*, so a new column is taken only after the previous one
// is through; the next start can transfer while its last pixel is shown.
// Reset: the random state goes to its seed, red_mode to 1, and all row valid
// bits clear, so every column reads as cold until first written.
// The receiver cannot hold results off; each pixel is shown for one cycle.
// csr_we writes red_mode (red-to-yellow when 1, green-to-yellow when 0);
// write it only while busy is low and no pixel is pending.
module led_fire_column_update_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lfcu_pkg::COORD_W-1:0]  req_column_x,
   input  logic [lfcu_pkg::COORD_W-1:0]  req_column_y,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   output logic                          rsp_valid,
   output logic [lfcu_pkg::COORD_W-1:0]  rsp_pixel_x,
   output logic [lfcu_pkg::COORD_W-1:0]  rsp_pixel_y,
   output logic [lfcu_pkg::COORD_W-1:0]  rsp_pixel_z,
   output logic [lfcu_pkg::LEVEL_W-1:0]  rsp_red_level,
   output logic [lfcu_pkg::LEVEL_W-1:0]  rsp_green_level,
   output logic                          rsp_last_pixel
);
   import lfcu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_COOL,
      S_SPARK,
      S_LOSS,
      S_SHIFT,
      S_PICK,
      S_IGN_LOAD,
      S_IGNITE,
      S_WRITE,
      S_EMIT,
      S_DRAIN
   } state_type;

   localparam logic [Z_W-1:0]    Z_LAST   = Z_W'(SIDE - 1);
   localparam logic [MOD_CW-1:0] MOD_LAST = MOD_CW'(MOD_STEPS - 1);

   // Heat row memory, one row per column
   logic [ROW_W-1:0]   heat_mem [ROWS];
   logic [ROWS-1:0]    row_valid_ff;
   logic [ROW_W-1:0]   rd_row_ff;
   logic               rd_valid_ff;

   // Sequencer state
   state_type          state_ff;
   logic [31:0]        prng_ff;
   logic [31:0]        prng_in;
   logic               red_mode_ff;
   logic [ROW_AW-1:0]  col_addr_ff;
   heat_type           col_ff [SIDE];
   logic [ROW_W-1:0]   col_row;
   logic [Z_W-1:0]     z_ff;
   heat_type           cool_div_ff;
   heat_type           spark_ff;
   logic               pick_ff;
   heat_type           loss_in;
   heat_type           cell_in;

   // Remainder unit
   logic [MOD_W-1:0]   mod_rem_ff;
   logic [MOD_W-1:0]   mod_rem_in;
   logic [MOD_W:0]     mod_trial;
   logic [DVD_W-1:0]   mod_dvd_ff;
   logic [MOD_W-1:0]   mod_div_ff;
   logic [MOD_CW-1:0]  mod_cnt_ff;
   logic               mod_done;

   // Color pipe
   logic               t_vld_ff;
   logic [LEVEL_W-1:0] t_ff;
   logic [Z_W-1:0]     t_z_ff;
   logic [LEVEL_W-1:0] r_coef_in;
   logic [LEVEL_W-1:0] g_coef_in;
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;
   logic [COORD_W-1:0] rsp_z_ff;
   logic [LEVEL_W-1:0] rsp_red_ff;
   logic [LEVEL_W-1:0] rsp_green_ff;
   logic               rsp_last_ff;

   assign prng_in  = xorshift(prng_ff);
   assign mod_done = (mod_cnt_ff == MOD_LAST);
   assign busy     = (state_ff != S_IDLE);

   // Four restoring remainder steps per cycle
   always_comb begin
      mod_rem_in = mod_rem_ff;
      mod_trial  = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         mod_trial = {mod_rem_in, mod_dvd_ff[DVD_W-1-i]};
         if (mod_trial >= {1'b0, mod_div_ff}) begin
            mod_trial = mod_trial - {1'b0, mod_div_ff};
         end
         mod_rem_in = mod_trial[MOD_W-1:0];
      end
   end

   // Current cell minus its loss, floored at zero
   always_comb begin
      loss_in = mod_rem_in[HEAT_W-1:0] + LOSS_BASE;
      cell_in = (col_ff[z_ff] > loss_in) ? (col_ff[z_ff] - loss_in) : '0;
   end

   // Row image for write-back
   always_comb begin
      for (int i = 0; i < SIDE; i++) begin
         col_row[i*HEAT_W +: HEAT_W] = col_ff[i];
      end
   end

   // Mode-dependent color coefficients
   always_comb begin
      if (red_mode_ff) begin
         r_coef_in = RED_FULL;
         g_coef_in = ramp(RED_RAMP, t_z_ff);
      end else begin
         r_coef_in = ramp(GREEN_RAMP, t_z_ff);
         g_coef_in = GREEN_FULL;
      end
   end

   // Heat memory: registered read on the start transfer, write-back in S_WRITE
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         rd_row_ff   <= heat_mem[{req_column_x, req_column_y}];
         rd_valid_ff <= row_valid_ff[{req_column_x, req_column_y}];
      end
      if (state_ff == S_WRITE) begin
         heat_mem[col_addr_ff] <= col_row;
      end
   end

   // Sequencer, remainder unit, color pipe and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prng_ff      <= PRNG_SEED;
         red_mode_ff  <= 1'b1;
         row_valid_ff <= '0;
         t_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            red_mode_ff <= csr_wdata;
         end

         // remainder unit free-runs; a load below overrides
         mod_rem_ff <= mod_rem_in;
         mod_dvd_ff <= mod_dvd_ff << MOD_BITS;
         mod_cnt_ff <= mod_cnt_ff + 1'b1;

         // color stage 2: scale coefficients by t
         t_vld_ff     <= 1'b0;
         rsp_valid_ff <= t_vld_ff;
         rsp_x_ff     <= col_addr_ff[ROW_AW-1:COORD_W];
         rsp_y_ff     <= col_addr_ff[COORD_W-1:0];
         rsp_z_ff     <= COORD_W'(t_z_ff);
         rsp_red_ff   <= div255(16'(r_coef_in) * 16'(t_ff));
         rsp_green_ff <= div255(16'(g_coef_in) * 16'(t_ff));
         rsp_last_ff  <= (t_z_ff == Z_LAST);

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  col_addr_ff <= {req_column_x, req_column_y};
                  prng_ff     <= prng_in;
                  mod_rem_ff  <= '0;
                  mod_dvd_ff  <= DVD_W'(prng_in[DRAW_W-1:0]);
                  mod_div_ff  <= COOL_SPAN;
                  mod_cnt_ff  <= '0;
                  state_ff    <= S_COOL;
               end
            end
            S_COOL: begin
               if (mod_done) begin
                  cool_div_ff <= HEAT_W'((mod_rem_in[HEAT_W-1:0] + COOL_BASE) / SIDE);
                  for (int i = 0; i < SIDE; i++) begin
                     col_ff[i] <= rd_valid_ff ? rd_row_ff[i*HEAT_W +: HEAT_W] : '0;
                  end
                  prng_ff    <= prng_in;
                  mod_rem_ff <= '0;
                  mod_dvd_ff <= DVD_W'(prng_in[DRAW_W-1:0]);
                  mod_div_ff <= SPARK_SPAN;
                  mod_cnt_ff <= '0;
                  state_ff   <= S_SPARK;
               end
            end
            S_SPARK: begin
               if (mod_done) begin
                  spark_ff   <= mod_rem_in[HEAT_W-1:0] + SPARK_BASE;
                  prng_ff    <= prng_in;
                  mod_rem_ff <= '0;
                  mod_dvd_ff <= DVD_W'(prng_in[DRAW_W-1:0]);
                  mod_div_ff <= {1'b0, cool_div_ff};
                  mod_cnt_ff <= '0;
                  z_ff       <= '0;
                  state_ff   <= S_LOSS;
               end
            end
            S_LOSS: begin
               if (mod_done) begin
                  col_ff[z_ff] <= cell_in;
                  if (z_ff == Z_LAST) begin
                     state_ff <= S_SHIFT;
                  end else begin
                     z_ff       <= z_ff + 1'b1;
                     prng_ff    <= prng_in;
                     mod_rem_ff <= '0;
                     mod_dvd_ff <= DVD_W'(prng_in[DRAW_W-1:0]);
                     mod_div_ff <= {1'b0, cool_div_ff};
                     mod_cnt_ff <= '0;
                  end
               end
            end
            S_SHIFT: begin
               // heat rises: cells 2 and up from the old cooled values
               for (int i = 2; i < SIDE; i++) begin
                  col_ff[i] <= div3({2'b00, col_ff[i-1]} + {1'b0, col_ff[i-2], 1'b0});
               end
               prng_ff <= prng_in;
               if (prng_in[HEAT_W-1:0] < spark_ff) begin
                  state_ff <= S_PICK;
               end else begin
                  state_ff <= S_WRITE;
               end
            end
            S_PICK: begin
               prng_ff  <= prng_in;
               pick_ff  <= prng_in[0];
               state_ff <= S_IGN_LOAD;
            end
            S_IGN_LOAD: begin
               prng_ff    <= prng_in;
               mod_rem_ff <= '0;
               mod_dvd_ff <= DVD_W'(prng_in[DRAW_W-1:0]);
               mod_div_ff <= HEAT_RANGE - {1'b0, col_ff[Z_W'(pick_ff)]};
               mod_cnt_ff <= '0;
               state_ff   <= S_IGNITE;
            end
            S_IGNITE: begin
               if (mod_done) begin
                  col_ff[Z_W'(pick_ff)] <= col_ff[Z_W'(pick_ff)] + mod_rem_in[HEAT_W-1:0];
                  state_ff              <= S_WRITE;
               end
            end
            S_WRITE: begin
               row_valid_ff[col_addr_ff] <= 1'b1;
               z_ff                      <= '0;
               state_ff                  <= S_EMIT;
            end
            S_EMIT: begin
               // color stage 1: t = heat * 191 / 255
               t_vld_ff <= 1'b1;
               t_ff     <= div255(16'(col_ff[z_ff]) * HEAT_SCALE);
               t_z_ff   <= z_ff;
               if (z_ff == Z_LAST) begin
                  state_ff <= S_DRAIN;
               end else begin
                  z_ff <= z_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_z     = rsp_z_ff;
   assign rsp_red_level   = rsp_red_ff;
   assign rsp_green_level = rsp_green_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule
